// ----- rtl/pfg_pkg.sv -----
`timescale 1ns / 1ps
package pfg_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int NLANE         = 3;
  localparam int MAG_W         = 33;   // |component| of a 33-bit difference
  localparam int ROOT_W        = 32;   // root of a 64-bit sum of squares
  localparam int LEN_W         = 33;   // vector length after rescale
  localparam int NUM_W         = 65;   // dividend: magnitude times capped force
  localparam int QUO_W         = 32;   // quotient bits below the overflow check

  typedef enum logic [1:0] {
    CMD_GRAVITY = 2'd0,
    CMD_DRAG    = 2'd1,
    CMD_SPRING  = 2'd2,
    CMD_BUNGEE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_GRAVITY_X      = 3'd0,
    REG_GRAVITY_Y      = 3'd1,
    REG_GRAVITY_Z      = 3'd2,
    REG_DRAG_LINEAR    = 3'd3,
    REG_DRAG_QUADRATIC = 3'd4,
    REG_STIFFNESS      = 3'd5,
    REG_NATURAL_LENGTH = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic [30:0]        inverse_mass;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
    logic               applied;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] gravity_x;
    logic signed [31:0] gravity_y;
    logic signed [31:0] gravity_z;
    logic [30:0]        drag_linear;
    logic [30:0]        drag_quadratic;
    logic [30:0]        stiffness;
    logic [30:0]        natural_length;
  } cfg_t;

  // item bookkeeping that rides along the length pipeline
  typedef struct packed {
    logic [1:0]                  cmd;
    logic                        big;
    logic [NLANE-1:0][MAG_W-1:0] mag;
    logic [NLANE-1:0]            pos_dir;
    logic [30:0]                 imass;
  } trk_t;

  // flags that ride along the divider
  typedef struct packed {
    logic             applied;
    logic             zero;
    logic             sat_cap;
    logic [NLANE-1:0] neg;
  } tag_t;

endpackage

// ----- rtl/pfg_vec.sv -----
`timescale 1ns / 1ps
module pfg_vec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pfg_pkg::in_item_t  in_item,
  output logic               vec_valid,
  output logic [63:0]        sumsq,
  output pfg_pkg::trk_t      vec_trk
);

  logic signed [32:0] p [3];
  logic signed [32:0] e [3];
  logic signed [32:0] v [3];
  logic signed [32:0] u [3];

  pfg_pkg::trk_t trk_nxt;
  pfg_pkg::trk_t trk_b_nxt;
  pfg_pkg::trk_t trk_a_r, trk_b_r, trk_c_r;
  logic          va_r, vb_r, vc_r;
  logic [2:0][63:0] sq_b_r;
  logic [63:0]      sum_c_r;
  logic             big;
  logic [2:0][31:0] h;

  assign p[0] = {in_item.pos_x[31], in_item.pos_x};
  assign p[1] = {in_item.pos_y[31], in_item.pos_y};
  assign p[2] = {in_item.pos_z[31], in_item.pos_z};
  assign e[0] = {in_item.end_x[31], in_item.end_x};
  assign e[1] = {in_item.end_y[31], in_item.end_y};
  assign e[2] = {in_item.end_z[31], in_item.end_z};
  assign v[0] = {in_item.vel_x[31], in_item.vel_x};
  assign v[1] = {in_item.vel_y[31], in_item.vel_y};
  assign v[2] = {in_item.vel_z[31], in_item.vel_z};

  // stage a: difference or velocity, magnitude and direction
  always_comb begin
    trk_nxt       = '0;
    trk_nxt.cmd   = in_item.cmd;
    trk_nxt.imass = in_item.inverse_mass;
    for (int i = 0; i < 3; i++) begin
      u[i] = (in_item.cmd == pfg_pkg::CMD_DRAG) ? v[i] : (p[i] - e[i]);
      trk_nxt.mag[i]     = u[i][32] ? 33'(-u[i]) : 33'(u[i]);
      trk_nxt.pos_dir[i] = !u[i][32] && (u[i] != '0);
    end
  end

  // stage b: halve when any component reaches 2^31, then square
  always_comb begin
    big = 1'b0;
    for (int i = 0; i < 3; i++) begin
      big = big | (trk_a_r.mag[i][32:31] != 2'b00);
    end
    for (int i = 0; i < 3; i++) begin
      h[i] = big ? trk_a_r.mag[i][32:1] : trk_a_r.mag[i][31:0];
    end
    trk_b_nxt     = trk_a_r;
    trk_b_nxt.big = big;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    trk_a_r <= trk_nxt;
    trk_b_r <= trk_b_nxt;
    for (int i = 0; i < 3; i++) begin
      sq_b_r[i] <= {32'b0, h[i]} * {32'b0, h[i]};
    end
    trk_c_r <= trk_b_r;
    sum_c_r <= sq_b_r[0] + sq_b_r[1] + sq_b_r[2];
  end

  assign vec_valid = vc_r;
  assign sumsq     = sum_c_r;
  assign vec_trk   = trk_c_r;

endmodule

// ----- rtl/pfg_sqrt.sv -----
`timescale 1ns / 1ps
module pfg_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [63:0]                   x,
  input  pfg_pkg::trk_t                 trk,
  output logic                          out_valid,
  output logic [pfg_pkg::ROOT_W-1:0]    root,
  output pfg_pkg::trk_t                 trk_out
);

  localparam int NST = pfg_pkg::ROOT_W;

  logic [65:0]       rem_r  [NST];
  logic [NST-1:0]    root_r [NST];
  pfg_pkg::trk_t     trk_r  [NST];
  logic              v_r    [NST];

  // one root bit per stage, remainder kept as x - root^2
  for (genvar s = 0; s < NST; s++) begin : g_st
    localparam int B = NST - 1 - s;
    logic [65:0]    rem_i;
    logic [65:0]    t;
    logic [NST-1:0] root_i;
    pfg_pkg::trk_t  trk_i;
    logic           v_i;

    if (s == 0) begin : g_first
      assign rem_i  = {2'b00, x};
      assign root_i = '0;
      assign trk_i  = trk;
      assign v_i    = in_valid;
    end else begin : g_next
      assign rem_i  = rem_r[s-1];
      assign root_i = root_r[s-1];
      assign trk_i  = trk_r[s-1];
      assign v_i    = v_r[s-1];
    end

    assign t = ({34'b0, root_i} << (B + 1)) | (66'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      trk_r[s] <= trk_i;
      if (rem_i >= t) begin
        rem_r[s]  <= rem_i - t;
        root_r[s] <= root_i | (NST'(1) << B);
      end else begin
        rem_r[s]  <= rem_i;
        root_r[s] <= root_i;
      end
    end
  end

  assign out_valid = v_r[NST-1];
  assign root      = root_r[NST-1];
  assign trk_out   = trk_r[NST-1];

endmodule

// ----- rtl/pfg_scale.sv -----
`timescale 1ns / 1ps
module pfg_scale #(
  parameter int FRAC_BITS = pfg_pkg::FRAC_BITS_DEF
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       in_valid,
  input  logic [pfg_pkg::ROOT_W-1:0]                 root,
  input  pfg_pkg::trk_t                              trk,
  input  pfg_pkg::cfg_t                              cfg,
  output logic                                       out_valid,
  output logic [pfg_pkg::NLANE-1:0][pfg_pkg::NUM_W-1:0] num,
  output logic [pfg_pkg::LEN_W-1:0]                  den,
  output pfg_pkg::tag_t                              tag
);

  logic [32:0] len;

  // m1
  logic          v1_r;
  pfg_pkg::trk_t trk1_r;
  logic [32:0]   len1_r, diff1_r;
  logic [63:0]   linp1_r, sq1_r;
  logic          slack1_r;
  // m2
  logic          v2_r;
  pfg_pkg::trk_t trk2_r;
  logic [32:0]   len2_r;
  logic          slack2_r;
  logic [63:0]   lin2_r, pplo2_r, pphi2_r, kd2_r;
  logic [63:0]   l2;
  // m3
  logic          v3_r;
  pfg_pkg::trk_t trk3_r;
  logic [32:0]   len3_r;
  logic          slack3_r;
  logic [63:0]   lin3_r, kd3_r;
  logic [95:0]   qsum3_r;
  // m4
  logic          v4_r;
  pfg_pkg::trk_t trk4_r;
  logic [32:0]   len4_r;
  logic          slack4_r;
  logic [31:0]   m4_r;
  logic          over4_r;
  logic [96:0]   mbig;
  // m5
  logic          v5_r;
  logic [2:0][64:0] num5_r;
  logic [32:0]   den5_r;
  pfg_pkg::tag_t tag5_r;
  pfg_pkg::tag_t tag_nxt;
  logic [2:0][64:0] num_nxt;
  logic signed [31:0] g [3];
  logic [32:0]   g33;
  logic [31:0]   gabs;
  logic          grav;

  assign len = trk.big ? {root, 1'b0} : {1'b0, root};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  // m1: k1*L, L*L (wraps at 64 bits), |L - rest|
  always_ff @(posedge clk) begin
    trk1_r   <= trk;
    len1_r   <= len;
    linp1_r  <= {33'b0, cfg.drag_linear} * {31'b0, len};
    sq1_r    <= {31'b0, len} * {31'b0, len};
    slack1_r <= len <= {2'b00, cfg.natural_length};
    if (len >= {2'b00, cfg.natural_length}) begin
      diff1_r <= len - {2'b00, cfg.natural_length};
    end else begin
      diff1_r <= {2'b00, cfg.natural_length} - len;
    end
  end

  // m2: quadratic term split into two partial products
  assign l2 = sq1_r >> FRAC_BITS;

  always_ff @(posedge clk) begin
    trk2_r   <= trk1_r;
    len2_r   <= len1_r;
    slack2_r <= slack1_r;
    lin2_r   <= linp1_r >> FRAC_BITS;
    pplo2_r  <= {33'b0, cfg.drag_quadratic} * {32'b0, l2[31:0]};
    pphi2_r  <= {33'b0, cfg.drag_quadratic} * {32'b0, l2[63:32]};
    kd2_r    <= {33'b0, cfg.stiffness} * {31'b0, diff1_r};
  end

  // m3: join partial products
  always_ff @(posedge clk) begin
    trk3_r   <= trk2_r;
    len3_r   <= len2_r;
    slack3_r <= slack2_r;
    lin3_r   <= lin2_r;
    kd3_r    <= kd2_r;
    qsum3_r  <= {pphi2_r, 32'b0} + {32'b0, pplo2_r};
  end

  // m4: force magnitude and cap at 2^32-1
  always_comb begin
    if (trk3_r.cmd == pfg_pkg::CMD_DRAG) begin
      mbig = {33'b0, lin3_r} + {1'b0, qsum3_r >> FRAC_BITS};
    end else begin
      mbig = {33'b0, kd3_r >> FRAC_BITS};
    end
  end

  always_ff @(posedge clk) begin
    trk4_r   <= trk3_r;
    len4_r   <= len3_r;
    slack4_r <= slack3_r;
    over4_r  <= mbig[96:32] != '0;
    m4_r     <= (mbig[96:32] != '0) ? '1 : mbig[31:0];
  end

  // m5: dividends, divisor and flags
  assign g[0] = cfg.gravity_x;
  assign g[1] = cfg.gravity_y;
  assign g[2] = cfg.gravity_z;
  assign grav = trk4_r.cmd == pfg_pkg::CMD_GRAVITY;

  always_comb begin
    g33  = '0;
    gabs = '0;
    tag_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      g33  = {g[i][31], g[i]};
      gabs = 32'(g[i][31] ? -g33 : g33);
      if (grav) begin
        num_nxt[i]     = {33'b0, gabs} << FRAC_BITS;
        tag_nxt.neg[i] = g[i][31];
      end else begin
        num_nxt[i]     = {32'b0, trk4_r.mag[i]} * {33'b0, m4_r};
        tag_nxt.neg[i] = trk4_r.pos_dir[i];
      end
    end
    if (grav) begin
      tag_nxt.applied = trk4_r.imass != '0;
    end else if (trk4_r.cmd == pfg_pkg::CMD_BUNGEE) begin
      tag_nxt.applied = !slack4_r;
    end else begin
      tag_nxt.applied = 1'b1;
    end
    tag_nxt.zero    = !grav && (len4_r == '0);
    tag_nxt.sat_cap = over4_r && !grav && tag_nxt.applied && !tag_nxt.zero;
  end

  always_ff @(posedge clk) begin
    num5_r <= num_nxt;
    den5_r <= grav ? {2'b00, trk4_r.imass} : len4_r;
    tag5_r <= tag_nxt;
  end

  assign out_valid = v5_r;
  assign num       = num5_r;
  assign den       = den5_r;
  assign tag       = tag5_r;

endmodule

// ----- rtl/pfg_div.sv -----
`timescale 1ns / 1ps
module pfg_div (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  logic [pfg_pkg::NLANE-1:0][pfg_pkg::NUM_W-1:0] num,
  input  logic [pfg_pkg::LEN_W-1:0]                     den,
  input  pfg_pkg::tag_t                                 tag,
  output logic                                          out_valid,
  output logic [pfg_pkg::NLANE-1:0][pfg_pkg::QUO_W-1:0] quo,
  output logic [pfg_pkg::NLANE-1:0]                     ovf,
  output pfg_pkg::tag_t                                 tag_out
);

  localparam int NST = pfg_pkg::QUO_W;

  // overflow check: quotient reaches 2^32 when the upper part is not below den
  logic             v0_r;
  logic [2:0][32:0] rem0_r;
  logic [2:0][31:0] low0_r;
  logic [2:0]       ovf0_r;
  logic [32:0]      den0_r;
  pfg_pkg::tag_t    tag0_r;

  logic [2:0][32:0] rem_r [NST];
  logic [2:0][31:0] low_r [NST];
  logic [2:0][31:0] q_r   [NST];
  logic [2:0]       ovf_r [NST];
  logic [32:0]      den_r [NST];
  pfg_pkg::tag_t    tag_r [NST];
  logic             v_r   [NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < 3; l++) begin
      ovf0_r[l] <= num[l][64:32] >= den;
      rem0_r[l] <= num[l][64:32];
      low0_r[l] <= num[l][31:0];
    end
    den0_r <= den;
    tag0_r <= tag;
  end

  for (genvar s = 0; s < NST; s++) begin : g_st
    logic [2:0][32:0] rem_i, rem_nxt;
    logic [2:0][31:0] low_i, q_i, q_nxt;
    logic [2:0]       ovf_i;
    logic [32:0]      den_i;
    pfg_pkg::tag_t    tag_i;
    logic             v_i;
    logic [33:0]      t;

    if (s == 0) begin : g_first
      assign rem_i = rem0_r;
      assign low_i = low0_r;
      assign q_i   = '0;
      assign ovf_i = ovf0_r;
      assign den_i = den0_r;
      assign tag_i = tag0_r;
      assign v_i   = v0_r;
    end else begin : g_next
      assign rem_i = rem_r[s-1];
      assign low_i = low_r[s-1];
      assign q_i   = q_r[s-1];
      assign ovf_i = ovf_r[s-1];
      assign den_i = den_r[s-1];
      assign tag_i = tag_r[s-1];
      assign v_i   = v_r[s-1];
    end

    // restoring step, one quotient bit per lane
    always_comb begin
      t = '0;
      for (int l = 0; l < 3; l++) begin
        t = {rem_i[l], low_i[l][31]};
        if (t >= {1'b0, den_i}) begin
          rem_nxt[l] = 33'(t - {1'b0, den_i});
          q_nxt[l]   = {q_i[l][30:0], 1'b1};
        end else begin
          rem_nxt[l] = t[32:0];
          q_nxt[l]   = {q_i[l][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s] <= 1'b0;
      end else begin
        v_r[s] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[s] <= rem_nxt;
      q_r[s]   <= q_nxt;
      for (int l = 0; l < 3; l++) begin
        low_r[s][l] <= {low_i[l][30:0], 1'b0};
      end
      ovf_r[s] <= ovf_i;
      den_r[s] <= den_i;
      tag_r[s] <= tag_i;
    end
  end

  assign out_valid = v_r[NST-1];
  assign quo       = q_r[NST-1];
  assign ovf       = ovf_r[NST-1];
  assign tag_out   = tag_r[NST-1];

endmodule

// ----- rtl/particle_force_generator_unit.sv -----
`timescale 1ns / 1ps
// path: vec, sqrt, scale and div stages, then the output register
// throughput: one item per cycle; busy stays low, the 32-stage root and
// 33-stage divider pipelines carry one item in each stage
// reset: synchronous active-low rst_n clears all stage valid bits and the
// configuration registers; the receiver cannot stall, results are never held
module particle_force_generator_unit #(
  parameter int FRAC_BITS = pfg_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // input items
  input  logic               start,
  output logic               busy,
  input  pfg_pkg::in_item_t  in_data,
  // results
  output logic               out_valid,
  output pfg_pkg::out_item_t out_data,
  // configuration writes
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  pfg_pkg::cfg_t cfg_r;

  logic          vec_valid;
  logic [63:0]   sumsq;
  pfg_pkg::trk_t vec_trk;

  logic                              sq_valid;
  logic [pfg_pkg::ROOT_W-1:0]        root;
  pfg_pkg::trk_t                     sq_trk;

  logic                                          sc_valid;
  logic [pfg_pkg::NLANE-1:0][pfg_pkg::NUM_W-1:0] num;
  logic [pfg_pkg::LEN_W-1:0]                     den;
  pfg_pkg::tag_t                                 sc_tag;

  logic                                          dv_valid;
  logic [pfg_pkg::NLANE-1:0][pfg_pkg::QUO_W-1:0] quo;
  logic [pfg_pkg::NLANE-1:0]                     ovf;
  pfg_pkg::tag_t                                 dv_tag;

  logic               out_valid_r;
  pfg_pkg::out_item_t out_r;
  pfg_pkg::out_item_t out_nxt;
  logic [2:0][31:0]   force_v;
  logic [2:0]         lane_sat;
  logic [32:0]        m33;
  logic [32:0]        mneg;

  // every cycle can take a transfer
  assign busy = 1'b0;

  // configuration registers, writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfg_pkg::REG_GRAVITY_X:      cfg_r.gravity_x      <= cfg_data;
        pfg_pkg::REG_GRAVITY_Y:      cfg_r.gravity_y      <= cfg_data;
        pfg_pkg::REG_GRAVITY_Z:      cfg_r.gravity_z      <= cfg_data;
        pfg_pkg::REG_DRAG_LINEAR:    cfg_r.drag_linear    <= cfg_data[30:0];
        pfg_pkg::REG_DRAG_QUADRATIC: cfg_r.drag_quadratic <= cfg_data[30:0];
        pfg_pkg::REG_STIFFNESS:      cfg_r.stiffness      <= cfg_data[30:0];
        pfg_pkg::REG_NATURAL_LENGTH: cfg_r.natural_length <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // vector, squares and their sum (3 stages)
  pfg_vec u_vec (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_item   (in_data),
    .vec_valid (vec_valid),
    .sumsq     (sumsq),
    .vec_trk   (vec_trk)
  );

  // vector length, one root bit per stage
  pfg_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vec_valid),
    .x         (sumsq),
    .trk       (vec_trk),
    .out_valid (sq_valid),
    .root      (root),
    .trk_out   (sq_trk)
  );

  // force magnitude per law and dividend set-up (5 stages)
  pfg_scale #(
    .FRAC_BITS (FRAC_BITS)
  ) u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .root      (root),
    .trk       (sq_trk),
    .cfg       (cfg_r),
    .out_valid (sc_valid),
    .num       (num),
    .den       (den),
    .tag       (sc_tag)
  );

  // three-lane divider: gravity over inverse mass, or |u_i|*M over length
  pfg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sc_valid),
    .num       (num),
    .den       (den),
    .tag       (sc_tag),
    .out_valid (dv_valid),
    .quo       (quo),
    .ovf       (ovf),
    .tag_out   (dv_tag)
  );

  // sign and 32-bit clip per component
  always_comb begin
    m33  = '0;
    mneg = '0;
    for (int i = 0; i < 3; i++) begin
      m33 = ovf[i] ? 33'h1_0000_0000 : {1'b0, quo[i]};
      if (!dv_tag.neg[i]) begin
        lane_sat[i] = m33 > 33'h0_7FFF_FFFF;
        force_v[i]  = lane_sat[i] ? 32'h7FFF_FFFF : m33[31:0];
      end else begin
        lane_sat[i] = m33 > 33'h0_8000_0000;
        mneg        = lane_sat[i] ? 33'h0_8000_0000 : m33;
        force_v[i]  = 32'(33'd0 - mneg);
      end
    end
    out_nxt.applied = dv_tag.applied;
    // skipped items and zero-length vectors give no force
    if (!dv_tag.applied || dv_tag.zero) begin
      out_nxt.force_x   = '0;
      out_nxt.force_y   = '0;
      out_nxt.force_z   = '0;
      out_nxt.saturated = 1'b0;
    end else begin
      out_nxt.force_x   = force_v[0];
      out_nxt.force_y   = force_v[1];
      out_nxt.force_z   = force_v[2];
      out_nxt.saturated = dv_tag.sat_cap || (lane_sat != '0);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ----- bench/tb_particle_force_generator_unit.sv -----
`timescale 1ns / 1ps
// testbench for the particle force unit: directed and random force requests
// are fed through the command port under several register settings; a
// behavioral force calculator predicts each result, and the result monitor
// compares every strobed result with the oldest prediction
module tb_particle_force_generator_unit;

  localparam int          PIPE_LAT   = 73;    // base of the extra wait in drain
  localparam logic [2:0]  REG_UNUSED = 3'd7;  // index with no register behind it
  localparam logic [63:0] U64_MAX    = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] FORCE_CAP  = 64'hFFFF_FFFF;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  pfg_pkg::in_item_t  in_data;
  logic               out_valid;
  pfg_pkg::out_item_t out_data;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [31:0]        cfg_data;

  // predictor copy of the register file
  logic signed [31:0] grav [3];
  logic [30:0] k_lin, k_quad, k_spring, rest_len;

  pfg_pkg::out_item_t force_q[$];   // predicted forces, oldest first
  int        err_count;
  bit        burst_mode;    // no idle cycles while set

  particle_force_generator_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // ---------------------------------------------------------------------
  // force calculator
  // ---------------------------------------------------------------------

  // floor square root, one result bit per step from the top
  function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] sq;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t  = r | (64'd1 << b);
      sq = t * t;
      if (sq <= {64'd0, x}) r = t;
    end
    return r;
  endfunction

  // vector length; components of 2^31 or more are halved first so the sum fits
  function automatic logic [63:0] vec_length(input logic [63:0] a [3]);
    logic [63:0] h [3];
    if (a[0] < 64'h8000_0000 && a[1] < 64'h8000_0000 && a[2] < 64'h8000_0000)
      return floor_sqrt(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    for (int i = 0; i < 3; i++) h[i] = a[i] >> 1;
    return 2 * floor_sqrt(h[0] * h[0] + h[1] * h[1] + h[2] * h[2]);
  endfunction

  // clip a signed magnitude into 32 bits
  function automatic logic [31:0] clip_force(input bit neg, input logic [127:0] m,
                                             output bit clipped);
    clipped = 1'b0;
    if (!neg) begin
      if (m > 128'h7FFF_FFFF) begin
        clipped = 1'b1;
        m = 128'h7FFF_FFFF;
      end
      return m[31:0];
    end
    if (m > 128'h8000_0000) begin
      clipped = 1'b1;
      m = 128'h8000_0000;
    end
    return 32'(-m[31:0]);
  endfunction

  function automatic pfg_pkg::out_item_t calc_force(input pfg_pkg::in_item_t it);
    pfg_pkg::out_item_t r;
    logic [31:0]  f [3];
    longint       u [3];
    logic [63:0]  a [3];
    logic [63:0]  len, mag, lin, l2, quad, diff;
    logic [127:0] prod;
    logic signed [31:0] pos [3];
    logic signed [31:0] oth [3];
    logic signed [31:0] vel [3];
    bit applied, sat, c;
    applied = 1'b1;
    sat     = 1'b0;
    mag     = '0;
    for (int i = 0; i < 3; i++) f[i] = '0;
    pos = '{it.pos_x, it.pos_y, it.pos_z};
    oth = '{it.end_x, it.end_y, it.end_z};
    vel = '{it.vel_x, it.vel_y, it.vel_z};
    if (pfg_pkg::cmd_t'(it.cmd) == pfg_pkg::CMD_GRAVITY) begin
      if (it.inverse_mass == '0) begin
        applied = 1'b0;
      end else begin
        for (int i = 0; i < 3; i++) begin
          prod = grav[i] < 0 ? 128'(-longint'(grav[i])) : 128'(grav[i]);
          prod = (prod << 16) / it.inverse_mass;
          f[i] = clip_force(grav[i] < 0, prod, c);
          sat |= c;
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (pfg_pkg::cmd_t'(it.cmd) == pfg_pkg::CMD_DRAG) u[i] = longint'(vel[i]);
        else u[i] = longint'(pos[i]) - longint'(oth[i]);
        a[i] = u[i] < 0 ? 64'(-u[i]) : 64'(u[i]);
      end
      len = vec_length(a);
      if (pfg_pkg::cmd_t'(it.cmd) == pfg_pkg::CMD_DRAG) begin
        lin  = 64'((128'(k_lin) * len) >> 16);
        // square wraps at 64 bits before the shift
        l2   = 64'(128'(len) * len);
        l2   = l2 >> 16;
        prod = 128'(k_quad) * l2;
        quad = prod > 128'(U64_MAX) ? U64_MAX : 64'(prod >> 16);
        prod = 128'(lin) + quad;
        mag  = prod > 128'(U64_MAX) ? U64_MAX : prod[63:0];
      end else if (pfg_pkg::cmd_t'(it.cmd) == pfg_pkg::CMD_BUNGEE && len <= rest_len) begin
        applied = 1'b0;   // slack bungee
      end else begin
        diff = len >= rest_len ? len - rest_len : rest_len - len;
        mag  = 64'((128'(k_spring) * diff) >> 16);
      end
      if (applied && len != 0) begin
        if (mag > FORCE_CAP) begin
          mag = FORCE_CAP;
          sat = 1'b1;
        end
        // force points against the vector
        for (int i = 0; i < 3; i++) begin
          f[i] = clip_force(u[i] > 0, (128'(a[i]) * mag) / len, c);
          sat |= c;
        end
      end
    end
    if (!applied) sat = 1'b0;
    r.force_x   = f[0];
    r.force_y   = f[1];
    r.force_z   = f[2];
    r.applied   = applied;
    r.saturated = sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // result monitor: every strobe must match the oldest prediction
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    pfg_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      if (force_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        err_count++;
      end else begin
        want = force_q.pop_front();
        if (out_data.force_x !== want.force_x) begin
          $display("%0t: force_x exp %h got %h", $time, want.force_x, out_data.force_x);
          err_count++;
        end
        if (out_data.force_y !== want.force_y) begin
          $display("%0t: force_y exp %h got %h", $time, want.force_y, out_data.force_y);
          err_count++;
        end
        if (out_data.force_z !== want.force_z) begin
          $display("%0t: force_z exp %h got %h", $time, want.force_z, out_data.force_z);
          err_count++;
        end
        if (out_data.applied !== want.applied) begin
          $display("%0t: applied exp %b got %b", $time, want.applied, out_data.applied);
          err_count++;
        end
        if (out_data.saturated !== want.saturated) begin
          $display("%0t: saturated exp %b got %b", $time, want.saturated,
                   out_data.saturated);
          err_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------

  // one command transfer, then a random idle gap unless burst mode is set
  task automatic send_item(input pfg_pkg::in_item_t it);
    bit taken;
    int gap;
    start   = 1'b1;
    in_data = it;
    do begin
      @(posedge clk);
      taken = !busy;
    end while (!taken);
    force_q = {force_q, calc_force(it)};
    @(negedge clk);
    gap = burst_mode ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start   = 1'b0;
      in_data = '0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (pfg_pkg::cfg_reg_t'(idx))
      pfg_pkg::REG_GRAVITY_X:      grav[0]  = val;
      pfg_pkg::REG_GRAVITY_Y:      grav[1]  = val;
      pfg_pkg::REG_GRAVITY_Z:      grav[2]  = val;
      pfg_pkg::REG_DRAG_LINEAR:    k_lin    = val[30:0];
      pfg_pkg::REG_DRAG_QUADRATIC: k_quad   = val[30:0];
      pfg_pkg::REG_STIFFNESS:      k_spring = val[30:0];
      pfg_pkg::REG_NATURAL_LENGTH: rest_len = val[30:0];
      default: ;          // unused index is ignored
    endcase
  endtask

  // let everything in flight come out before the registers move
  task automatic drain();
    start = 1'b0;
    while (force_q.size() != 0) @(negedge clk);
    repeat (PIPE_LAT + 8) @(negedge clk);
  endtask

  task automatic load_regs(input logic [31:0] gx, gy, gz, kl, kq, ks, rl);
    drain();
    write_reg(pfg_pkg::REG_GRAVITY_X, gx);
    write_reg(pfg_pkg::REG_GRAVITY_Y, gy);
    write_reg(pfg_pkg::REG_GRAVITY_Z, gz);
    write_reg(pfg_pkg::REG_DRAG_LINEAR, kl);
    write_reg(pfg_pkg::REG_DRAG_QUADRATIC, kq);
    write_reg(pfg_pkg::REG_STIFFNESS, ks);
    write_reg(pfg_pkg::REG_NATURAL_LENGTH, rl);
  endtask

  // value mix: extremes, small numbers and full-range noise
  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
      3: return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic pfg_pkg::in_item_t mk_item(input pfg_pkg::cmd_t c,
      input logic signed [31:0] px, py, pz, ex, ey, ez, vx, vy, vz,
      input logic [30:0] im);
    pfg_pkg::in_item_t it;
    it = '{cmd: c, pos_x: px, pos_y: py, pos_z: pz, end_x: ex, end_y: ey,
           end_z: ez, vel_x: vx, vel_y: vy, vel_z: vz, inverse_mass: im};
    return it;
  endfunction

  function automatic pfg_pkg::in_item_t rand_item();
    pfg_pkg::in_item_t it;
    it.cmd   = 2'($urandom_range(0, 3));
    it.pos_x = pick32();
    it.pos_y = pick32();
    it.pos_z = pick32();
    // other end mostly near the particle so stretch and slack both show up
    if ($urandom_range(0, 3) != 0) begin
      it.end_x = it.pos_x + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      it.end_y = it.pos_y + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      it.end_z = it.pos_z + 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    end else begin
      it.end_x = pick32();
      it.end_y = pick32();
      it.end_z = pick32();
    end
    it.vel_x = pick32();
    it.vel_y = pick32();
    it.vel_z = pick32();
    case ($urandom_range(0, 5))
      0: it.inverse_mass = '0;
      1: it.inverse_mass = 31'h7FFF_FFFF;
      2: it.inverse_mass = 31'($urandom_range(1, 32'h0004_0000));
      default: it.inverse_mass = 31'($urandom);
    endcase
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------

  task automatic test_gravity();
    load_regs(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFF6_0000, 0, 0, 0, 0);
    // infinite mass
    send_item(mk_item(pfg_pkg::CMD_GRAVITY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd0));
    // clips at unit inverse mass, then larger inverse masses
    send_item(mk_item(pfg_pkg::CMD_GRAVITY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd1));
    send_item(mk_item(pfg_pkg::CMD_GRAVITY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h0001_0000));
    send_item(mk_item(pfg_pkg::CMD_GRAVITY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31'h7FFF_FFFF));
  endtask

  task automatic test_drag();
    load_regs(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    // zero velocity
    send_item(mk_item(pfg_pkg::CMD_DRAG, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // halved length, then a vector just below the halving bound
    send_item(mk_item(pfg_pkg::CMD_DRAG, 0, 0, 0, 0, 0, 0, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 0));
    send_item(mk_item(pfg_pkg::CMD_DRAG, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, -32'sd1, 0, 0));
    load_regs(0, 0, 0, 32'h0000_8000, 32'h0000_0100, 0, 0);
    send_item(mk_item(pfg_pkg::CMD_DRAG, 0, 0, 0, 0, 0, 0, 32'h0003_0000,
                      -32'sh0004_0000, 0, 0));
  endtask

  task automatic test_spring_bungee();
    load_regs(0, 0, 0, 0, 0, 32'h0002_0000, 32'h0005_0000);
    // zero offset
    send_item(mk_item(pfg_pkg::CMD_SPRING, 7, 7, 7, 7, 7, 7, 0, 0, 0, 0));
    // compressed, then stretched far
    send_item(mk_item(pfg_pkg::CMD_SPRING, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(pfg_pkg::CMD_SPRING, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0));
    // slack
    send_item(mk_item(pfg_pkg::CMD_BUNGEE, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // at rest, then stretched
    send_item(mk_item(pfg_pkg::CMD_BUNGEE, 32'h0005_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(pfg_pkg::CMD_BUNGEE, 0, -32'sh0009_0000, 0, 0, 0, 0, 0, 0, 0, 0));
    load_regs(0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0);
    // magnitude cap
    send_item(mk_item(pfg_pkg::CMD_SPRING, 32'h8000_0000, 32'h7FFF_FFFF, 0,
                      32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0));
    send_item(mk_item(pfg_pkg::CMD_BUNGEE, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0,
                      0, 0, 0, 0));
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) begin
        load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      end else begin
        load_regs($urandom, pick32(), 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000,
                  $urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0000_4000),
                  phase == 0 ? $urandom : $urandom_range(0, 32'h0008_0000),
                  $urandom_range(0, 32'h0006_0000));
        write_reg(REG_UNUSED, $urandom);
      end
      for (int n = 0; n < 170; n++) begin
        if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
        send_item(rand_item());
      end
      burst_mode = 1'b0;
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    err_count = 0;
    burst_mode = 1'b0;
    for (int i = 0; i < 3; i++) grav[i] = '0;
    k_lin = '0; k_quad = '0; k_spring = '0; rest_len = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    // reset register values first: gravity is zero, drag and spring have no strength
    send_item(mk_item(pfg_pkg::CMD_GRAVITY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 31'd3));
    send_item(mk_item(pfg_pkg::CMD_SPRING, 32'h0001_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    test_gravity();
    test_drag();
    test_spring_bungee();
    test_random();
    drain();
    if (err_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
